[sv/scbp_pkg.sv]
// Shared types, constants and codes for the size-class block pool.
package scbp_pkg;

  localparam int AddrW  = 48;
  localparam int SizeW  = 32;
  localparam int BytesW = 40;
  localparam int AccW   = BytesW + 1;

  localparam int MinBlockBytes   = 4096;
  localparam int NumClassesDef   = 15;
  localparam int StackDepthDef   = 4;
  localparam int AddrBitsDef     = 48;

  localparam logic [BytesW-1:0] ThreshRst = 40'd1073741824;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_TRIM  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    KIND_HIT       = 3'd0,
    KIND_FETCH     = 3'd1,
    KIND_POOLED    = 3'd2,
    KIND_RELEASE   = 3'd3,
    KIND_TRIM_DONE = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_ALLOC,
    S_HIT,
    S_FREE,
    S_FREE2,
    S_TRIM,
    S_TSUB,
    S_TPOP
  } state_e;

  typedef struct packed {
    logic            sub;
    logic [AccW-1:0] a;
    logic [AccW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [AccW-1:0] res;
    logic            ge;
  } alu_rsp_t;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [AddrW-1:0]  addr;
    logic [SizeW-1:0]  bytes;
    logic [BytesW-1:0] total;
    logic              last;
  } emit_t;

endpackage

[sv/scbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scbp_ram #(
  parameter int Width = 48,
  parameter int Depth = 60,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/scbp_alu.sv]
// Shared add/subtract and compare unit used by the pool sequencer.
module scbp_alu (
  input  scbp_pkg::alu_req_t req_i,
  output scbp_pkg::alu_rsp_t rsp_o
);

  localparam int WideW = scbp_pkg::AccW + 1;

  logic [scbp_pkg::AccW-1:0] b_eff;
  logic [WideW-1:0]          wide;

  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign wide  = {1'b0, req_i.a} + {1'b0, b_eff} + WideW'(req_i.sub);

  // on a subtract the carry out means a >= b
  assign rsp_o.res = wide[scbp_pkg::AccW-1:0];
  assign rsp_o.ge  = wide[WideW-1];

endmodule

[sv/scbp_seq.sv]
// Sequencer: class search, per-class stack counts, pooled total and trim walk.
module scbp_seq #(
  parameter int NUM_CLASSES = scbp_pkg::NumClassesDef,
  parameter int STACK_DEPTH = scbp_pkg::StackDepthDef,
  parameter int StW         = 48,
  parameter int RamAw       = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [scbp_pkg::SizeW-1:0]  size_bytes_i,
  input  logic [scbp_pkg::AddrW-1:0]  address_i,
  input  logic [scbp_pkg::BytesW-1:0] keep_bytes_i,
  input  logic [scbp_pkg::BytesW-1:0] thresh_i,
  input  logic                        out_free_i,
  output scbp_pkg::emit_t             emit_o,
  output scbp_pkg::alu_req_t          alu_req_o,
  input  scbp_pkg::alu_rsp_t          alu_rsp_i,
  output logic                        ram_we_o,
  output logic [RamAw-1:0]            ram_waddr_o,
  output logic [StW-1:0]              ram_wdata_o,
  output logic                        ram_re_o,
  output logic [RamAw-1:0]            ram_raddr_o,
  input  logic [StW-1:0]              ram_rdata_i
);

  localparam int ClsW = $clog2(NUM_CLASSES + 1);
  localparam int IdxW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int AccW = scbp_pkg::AccW;
  localparam int BW   = scbp_pkg::BytesW;

  scbp_pkg::state_e state_q, state_d;
  logic [1:0]                 req_q, req_d;
  logic [scbp_pkg::SizeW-1:0] size_q, size_d;
  logic [StW-1:0]             addr_q, addr_d;
  logic [BW-1:0]              keep_q, keep_d;
  logic [ClsW-1:0]            cls_q, cls_d;
  logic [AccW-1:0]            acc_q, acc_d;
  logic [BW-1:0]              pooled_q, pooled_d;
  logic [BW-1:0]              total_q, total_d;
  logic [CntW-1:0]            count_q [NUM_CLASSES];
  logic [CntW-1:0]            count_d [NUM_CLASSES];

  logic [AccW-1:0] csize;
  logic            over;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] cnt_cur;
  logic [ClsW-1:0] cls_wrap;
  logic [RamAw-1:0] slot_top;
  logic [RamAw-1:0] slot_free;

  assign csize     = AccW'(scbp_pkg::MinBlockBytes) << cls_q;
  assign over      = (cls_q == ClsW'(NUM_CLASSES));
  assign idx       = cls_q[IdxW-1:0];
  assign cnt_cur   = count_q[idx];
  assign cls_wrap  = (cls_q == ClsW'(NUM_CLASSES - 1)) ? '0 : cls_q + ClsW'(1);
  assign slot_free = RamAw'(int'(idx) * STACK_DEPTH + int'(cnt_cur));
  assign slot_top  = slot_free - RamAw'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scbp_pkg::S_IDLE;
      pooled_q <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      pooled_q <= pooled_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    size_q  <= size_d;
    addr_q  <= addr_d;
    keep_q  <= keep_d;
    cls_q   <= cls_d;
    acc_q   <= acc_d;
    total_q <= total_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    size_d      = size_q;
    addr_d      = addr_q;
    keep_d      = keep_q;
    cls_d       = cls_q;
    acc_d       = acc_q;
    pooled_d    = pooled_q;
    total_d     = total_q;
    count_d     = count_q;
    in_stall_o  = 1'b1;
    emit_o      = '0;
    emit_o.kind = scbp_pkg::KIND_HIT;
    emit_o.last = 1'b1;
    alu_req_o   = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot_free;
    ram_wdata_o = addr_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = slot_top;

    case (state_q)
      scbp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d   = req_type_i;
          size_d  = size_bytes_i;
          addr_d  = address_i[StW-1:0];
          keep_d  = keep_bytes_i;
          cls_d   = '0;
          total_d = '0;
          case (scbp_pkg::req_e'(req_type_i))
            scbp_pkg::REQ_ALLOC: state_d = scbp_pkg::S_CLASS;
            scbp_pkg::REQ_FREE:  state_d = scbp_pkg::S_CLASS;
            scbp_pkg::REQ_TRIM:  state_d = scbp_pkg::S_TRIM;
            default:             state_d = scbp_pkg::S_IDLE;
          endcase
        end
      end

      // smallest class whose size covers the request, one class a cycle
      scbp_pkg::S_CLASS: begin
        alu_req_o.sub = 1'b1;
        alu_req_o.a   = csize;
        alu_req_o.b   = AccW'(size_q);
        if (over || alu_rsp_i.ge) begin
          state_d = (req_q == scbp_pkg::REQ_ALLOC) ? scbp_pkg::S_ALLOC : scbp_pkg::S_FREE;
        end else begin
          cls_d = cls_q + ClsW'(1);
        end
      end

      scbp_pkg::S_ALLOC: begin
        if (!over && cnt_cur != '0) begin
          ram_re_o      = 1'b1;
          count_d[idx]  = cnt_cur - CntW'(1);
          alu_req_o.sub = 1'b1;
          alu_req_o.a   = AccW'(pooled_q);
          alu_req_o.b   = csize;
          pooled_d      = alu_rsp_i.res[BW-1:0];
          state_d       = scbp_pkg::S_HIT;
        end else if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.kind  = scbp_pkg::KIND_FETCH;
          emit_o.bytes = over ? size_q : csize[scbp_pkg::SizeW-1:0];
          state_d      = scbp_pkg::S_IDLE;
        end
      end

      scbp_pkg::S_HIT: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.kind  = scbp_pkg::KIND_HIT;
          emit_o.addr  = scbp_pkg::AddrW'(ram_rdata_i);
          state_d      = scbp_pkg::S_IDLE;
        end
      end

      scbp_pkg::S_FREE: begin
        if (!over && cnt_cur < CntW'(STACK_DEPTH)) begin
          alu_req_o.a = AccW'(pooled_q);
          alu_req_o.b = csize;
          acc_d       = alu_rsp_i.res;
          state_d     = scbp_pkg::S_FREE2;
        end else if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.kind  = scbp_pkg::KIND_RELEASE;
          emit_o.addr  = scbp_pkg::AddrW'(addr_q);
          emit_o.bytes = over ? size_q : csize[scbp_pkg::SizeW-1:0];
          state_d      = scbp_pkg::S_IDLE;
        end
      end

      // acc_q holds pooled plus class size; release if it reaches the threshold
      scbp_pkg::S_FREE2: begin
        alu_req_o.sub = 1'b1;
        alu_req_o.a   = acc_q;
        alu_req_o.b   = AccW'(thresh_i);
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          state_d      = scbp_pkg::S_IDLE;
          if (alu_rsp_i.ge) begin
            emit_o.kind  = scbp_pkg::KIND_RELEASE;
            emit_o.addr  = scbp_pkg::AddrW'(addr_q);
            emit_o.bytes = csize[scbp_pkg::SizeW-1:0];
          end else begin
            emit_o.kind  = scbp_pkg::KIND_POOLED;
            ram_we_o     = 1'b1;
            count_d[idx] = cnt_cur + CntW'(1);
            pooled_d     = acc_q[BW-1:0];
          end
        end
      end

      // round-robin walk; stops once keep >= pooled
      scbp_pkg::S_TRIM: begin
        alu_req_o.sub = 1'b1;
        alu_req_o.a   = AccW'(keep_q);
        alu_req_o.b   = AccW'(pooled_q);
        if (alu_rsp_i.ge) begin
          if (out_free_i) begin
            emit_o.valid = 1'b1;
            emit_o.kind  = scbp_pkg::KIND_TRIM_DONE;
            emit_o.total = total_q;
            state_d      = scbp_pkg::S_IDLE;
          end
        end else if (cnt_cur != '0) begin
          ram_re_o     = 1'b1;
          count_d[idx] = cnt_cur - CntW'(1);
          state_d      = scbp_pkg::S_TSUB;
        end else begin
          cls_d = cls_wrap;
        end
      end

      scbp_pkg::S_TSUB: begin
        alu_req_o.sub = 1'b1;
        alu_req_o.a   = AccW'(pooled_q);
        alu_req_o.b   = csize;
        pooled_d      = alu_rsp_i.res[BW-1:0];
        state_d       = scbp_pkg::S_TPOP;
      end

      scbp_pkg::S_TPOP: begin
        alu_req_o.a = AccW'(total_q);
        alu_req_o.b = csize;
        if (out_free_i) begin
          total_d      = alu_rsp_i.res[BW-1:0];
          emit_o.valid = 1'b1;
          emit_o.kind  = scbp_pkg::KIND_RELEASE;
          emit_o.addr  = scbp_pkg::AddrW'(ram_rdata_i);
          emit_o.bytes = csize[scbp_pkg::SizeW-1:0];
          emit_o.last  = 1'b0;
          cls_d        = cls_wrap;
          state_d      = scbp_pkg::S_TRIM;
        end
      end

      default: begin
        state_d = scbp_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("stack RAM read and write in one cycle");

  a_read_then_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |=> (state_q == scbp_pkg::S_HIT || state_q == scbp_pkg::S_TSUB))
    else $error("stack read not followed by its consumer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != scbp_pkg::S_IDLE && !over) |-> (cnt_cur <= CntW'(STACK_DEPTH)))
    else $error("class count beyond stack depth");

  a_last_only_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && !emit_o.last) |-> (state_q == scbp_pkg::S_TPOP))
    else $error("non-final beat outside trim walk");
`endif

endmodule

[sv/size_class_block_pool.sv]
// Size-class block pool: per-class LIFO stacks of freed addresses with a shared adder.
// An allocate or free first searches for its class, one class per cycle through the
// shared adder, with one more state for a pool hit or a free that passes the stack-full
// check; an oversized request searches all NUM_CLASSES classes. A trim walks the classes
// round-robin, popping one block from each non-empty class it visits until keep covers
// the pooled total, then sends a done beat. A result stalled downstream holds the
// sequencer until the result register frees. The block takes one request at a time; the
// result register lets the next request start while the previous beat is still waiting.
module size_class_block_pool #(
  parameter int NUM_CLASSES = scbp_pkg::NumClassesDef,
  parameter int STACK_DEPTH = scbp_pkg::StackDepthDef,
  parameter int ADDR_BITS   = scbp_pkg::AddrBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [scbp_pkg::BytesW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [scbp_pkg::SizeW-1:0]  size_bytes_i,
  input  logic [scbp_pkg::AddrW-1:0]  address_i,
  input  logic [scbp_pkg::BytesW-1:0] keep_bytes_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  kind_o,
  output logic [scbp_pkg::AddrW-1:0]  address_res_o,
  output logic [scbp_pkg::SizeW-1:0]  block_bytes_o,
  output logic [scbp_pkg::BytesW-1:0] released_total_o,
  output logic                        last_o
);

  localparam int StW      = (ADDR_BITS < scbp_pkg::AddrW) ? ADDR_BITS : scbp_pkg::AddrW;
  localparam int RamDepth = NUM_CLASSES * STACK_DEPTH;
  localparam int RamAw    = (RamDepth > 1) ? $clog2(RamDepth) : 1;

  logic [scbp_pkg::BytesW-1:0] thresh_q;
  logic                        out_valid_q;
  scbp_pkg::emit_t             out_q;
  logic                        out_free;

  scbp_pkg::emit_t    emit;
  scbp_pkg::alu_req_t alu_req;
  scbp_pkg::alu_rsp_t alu_rsp;

  logic             ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [StW-1:0]   ram_wdata;
  logic             ram_re;
  logic [RamAw-1:0] ram_raddr;
  logic [StW-1:0]   ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= scbp_pkg::ThreshRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      if (emit.valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat register, loaded only when free
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign address_res_o    = out_q.addr;
  assign block_bytes_o    = out_q.bytes;
  assign released_total_o = out_q.total;
  assign last_o           = out_q.last;

  scbp_seq #(
    .NUM_CLASSES (NUM_CLASSES),
    .STACK_DEPTH (STACK_DEPTH),
    .StW         (StW),
    .RamAw       (RamAw)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .size_bytes_i (size_bytes_i),
    .address_i    (address_i),
    .keep_bytes_i (keep_bytes_i),
    .thresh_i     (thresh_q),
    .out_free_i   (out_free),
    .emit_o       (emit),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  scbp_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  scbp_ram #(
    .Width (StW),
    .Depth (RamDepth),
    .Aw    (RamAw)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> out_free)
    else $error("result beat produced while output register busy");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o &&
     (req_type_i == scbp_pkg::REQ_ALLOC || req_type_i == scbp_pkg::REQ_FREE ||
      req_type_i == scbp_pkg::REQ_TRIM)) |=> in_stall_o)
    else $error("request accepted without going busy");

  a_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(address_res_o)))
    else $error("stalled result beat lost");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench for the size-class block pool: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb;
  import scbp_pkg::*;

  localparam int NumCls   = NumClassesDef;
  localparam int Depth    = StackDepthDef;
  localparam int BaseLog  = $clog2(MinBlockBytes);
  localparam int SettleCy = 64;

  localparam logic [1:0] ReqUnused = 2'd3;

  typedef struct {
    logic [1:0]        req;
    logic [SizeW-1:0]  size;
    logic [AddrW-1:0]  addr;
    logic [BytesW-1:0] keep;
  } pool_req_t;

  typedef struct {
    kind_e             kind;
    logic [AddrW-1:0]  addr;
    logic [SizeW-1:0]  bytes;
    logic [BytesW-1:0] total;
    logic              last;
  } pool_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [BytesW-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic [1:0]        req_type_i = '0;
  logic [SizeW-1:0]  size_bytes_i = '0;
  logic [AddrW-1:0]  address_i = '0;
  logic [BytesW-1:0] keep_bytes_i = '0;
  logic              out_stall_i = 1'b0;

  logic              cfg_ready_o;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [2:0]        kind_o;
  logic [AddrW-1:0]  address_res_o;
  logic [SizeW-1:0]  block_bytes_o;
  logic [BytesW-1:0] released_total_o;
  logic              last_o;

  size_class_block_pool u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .size_bytes_i     (size_bytes_i),
    .address_i        (address_i),
    .keep_bytes_i     (keep_bytes_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .address_res_o    (address_res_o),
    .block_bytes_o    (block_bytes_o),
    .released_total_o (released_total_o),
    .last_o           (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow of the pool contents
  logic [AddrW-1:0]  shadow_stack [NumCls][Depth];
  int unsigned       shadow_count [NumCls];
  longint unsigned   shadow_pooled = 0;
  logic [BytesW-1:0] shadow_thresh = ThreshRst;

  pool_req_t  pending [$];
  pool_beat_t beats_due [$];

  int errors = 0;
  int n_req = 0;
  int n_beats = 0;
  int n_trims = 0;
  int longest_trim = 0;
  int n_cfg = 0;

  function automatic int unsigned size_class(logic [SizeW-1:0] sz);
    int unsigned n;
    n = 0;
    while (n < 63 && (64'd1 << n) < sz) n++;
    return (n <= BaseLog) ? 0 : n - BaseLog;
  endfunction

  function automatic longint unsigned class_bytes(int unsigned c);
    return 64'(MinBlockBytes) << c;
  endfunction

  function automatic void post_beat(kind_e k, logic [AddrW-1:0] a, logic [SizeW-1:0] b,
                                    logic [BytesW-1:0] t, logic l);
    pool_beat_t e;
    e.kind  = k;
    e.addr  = a;
    e.bytes = b;
    e.total = t;
    e.last  = l;
    beats_due.push_back(e);
  endfunction

  function automatic void apply_req(pool_req_t r);
    int unsigned     c;
    int unsigned     i;
    int unsigned     guard;
    int              k;
    longint unsigned cb;
    longint unsigned total;
    c = size_class(r.size);
    cb = class_bytes(c);
    n_req++;
    case (r.req)
      REQ_ALLOC: begin
        if (c >= NumCls) begin
          post_beat(KIND_FETCH, '0, r.size, '0, 1'b1);
        end else if (shadow_count[c] > 0) begin
          shadow_count[c]--;
          shadow_pooled -= cb;
          post_beat(KIND_HIT, shadow_stack[c][shadow_count[c]], '0, '0, 1'b1);
        end else begin
          post_beat(KIND_FETCH, '0, SizeW'(cb), '0, 1'b1);
        end
      end
      REQ_FREE: begin
        if (c >= NumCls) begin
          post_beat(KIND_RELEASE, r.addr, r.size, '0, 1'b1);
        end else if (shadow_pooled + cb >= 64'(shadow_thresh) || shadow_count[c] >= Depth) begin
          post_beat(KIND_RELEASE, r.addr, SizeW'(cb), '0, 1'b1);
        end else begin
          shadow_stack[c][shadow_count[c]] = r.addr;
          shadow_count[c]++;
          shadow_pooled += cb;
          post_beat(KIND_POOLED, '0, '0, '0, 1'b1);
        end
      end
      REQ_TRIM: begin
        k = 0;
        total = 0;
        i = 0;
        guard = 0;
        // round-robin walk from class 0, bounded by an iteration guard
        while (shadow_pooled > 64'(r.keep) && guard < NumCls * (Depth + 1)) begin
          if (shadow_count[i] > 0) begin
            shadow_count[i]--;
            shadow_pooled -= class_bytes(i);
            total += class_bytes(i);
            post_beat(KIND_RELEASE, shadow_stack[i][shadow_count[i]],
                      SizeW'(class_bytes(i)), '0, 1'b0);
            k++;
          end
          i = (i + 1) % NumCls;
          guard++;
        end
        post_beat(KIND_TRIM_DONE, '0, '0, BytesW'(total), 1'b1);
        n_trims++;
        if (k + 1 > longest_trim) longest_trim = k + 1;
      end
      default: ;
    endcase
  endfunction

  // Wait length per request or beat, with occasional runs of back-to-back ones
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Request driver
  pool_req_t cur;
  int in_gap = 0;
  int in_calm = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_req(cur);
        in_gap = draw_wait(in_calm);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= cur.req;
          size_bytes_i <= cur.size;
          address_i    <= cur.addr;
          keep_bytes_i <= cur.keep;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  pool_beat_t want;
  int out_wait = 0;
  int out_calm = 0;

  task automatic flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_beats++;
        if (beats_due.size() == 0) begin
          flag($sformatf("%0t: unexpected beat kind %0d addr %h bytes %h total %h last %b",
                         $realtime, kind_o, address_res_o, block_bytes_o, released_total_o,
                         last_o));
        end else begin
          want = beats_due.pop_front();
          if (kind_o !== want.kind || address_res_o !== want.addr ||
              block_bytes_o !== want.bytes || released_total_o !== want.total ||
              last_o !== want.last) begin
            flag($sformatf({"%0t: beat mismatch exp kind %0d addr %h bytes %h total %h last %b,",
                            " got kind %0d addr %h bytes %h total %h last %b"},
                           $realtime, want.kind, want.addr, want.bytes, want.total, want.last,
                           kind_o, address_res_o, block_bytes_o, released_total_o, last_o));
          end
        end
        out_wait = draw_wait(out_calm);
      end
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [AddrW-1:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [SizeW-1:0] size_in_class(int unsigned c);
    logic [SizeW-1:0] cb;
    cb = SizeW'(class_bytes(c));
    if (c == 0) return $urandom_range(0, cb);
    return cb - $urandom_range(0, cb / 2 - 1);
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= 92) return $urandom;   // mostly oversized
    if (r < 75) return size_in_class($urandom_range(0, 3));
    return size_in_class($urandom_range(4, NumCls - 1));
  endfunction

  task automatic add_req(logic [1:0] req, logic [SizeW-1:0] sz, logic [AddrW-1:0] a,
                         logic [BytesW-1:0] keep);
    pool_req_t r;
    r.req  = req;
    r.size = sz;
    r.addr = a;
    r.keep = keep;
    pending.push_back(r);
  endtask

  task automatic queue_random(int n);
    int cnt;
    int unsigned r;
    logic [BytesW-1:0] keep;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       keep = '0;
        1:       keep = {8'($urandom), $urandom};
        default: keep = $urandom_range(0, 1 << 22);
      endcase
      if (r < 44) begin
        add_req(REQ_ALLOC, pick_size(), rand_addr(), keep);
        cnt++;
      end else if (r < 88) begin
        add_req(REQ_FREE, pick_size(), rand_addr(), keep);
        cnt++;
      end else if (r < 95) begin
        add_req(REQ_TRIM, $urandom, rand_addr(), keep);
        cnt++;
      end else begin
        add_req(ReqUnused, $urandom, rand_addr(), keep);
      end
    end
  endtask

  // Wait for every queued request and beat, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || beats_due.size() != 0) @(negedge clk_i);
    repeat (SettleCy) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [BytesW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_thresh = v;
    n_cfg++;
  endtask

  initial begin
    foreach (shadow_count[c]) shadow_count[c] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, class edges, full stack, oversized, trims
    add_req(REQ_ALLOC, 32'd0, '0, '0);
    add_req(REQ_ALLOC, '1, '0, '0);
    add_req(REQ_ALLOC, 32'd67108864, '0, '0);
    add_req(REQ_ALLOC, 32'd67108865, '0, '0);
    add_req(REQ_FREE, 32'd0, '0, '0);
    add_req(REQ_FREE, 32'd4096, '1, '0);
    add_req(REQ_FREE, 32'd1, rand_addr(), '0);
    add_req(REQ_FREE, 32'd4000, rand_addr(), '0);
    add_req(REQ_FREE, 32'd4096, rand_addr(), '0);
    add_req(REQ_FREE, 32'd4097, rand_addr(), '0);
    add_req(REQ_FREE, 32'd67108864, rand_addr(), '0);
    add_req(REQ_FREE, '1, '1, '0);
    add_req(REQ_FREE, 32'd67108865, rand_addr(), '0);
    add_req(REQ_ALLOC, 32'd4096, '0, '0);
    add_req(REQ_ALLOC, 32'd8192, '0, '0);
    add_req(ReqUnused, '1, '1, '1);
    add_req(REQ_TRIM, '0, '0, '1);
    add_req(REQ_TRIM, '0, '0, 40'd40000);
    add_req(REQ_TRIM, '1, '1, '0);
    add_req(REQ_TRIM, '0, '0, '0);
    add_req(REQ_ALLOC, 32'd4096, '1, '1);
    settle();

    // full scale threshold: fill every stack, then drain it in one trim
    write_thresh('1);
    for (int c = 0; c < NumCls; c++) begin
      for (int k = 0; k < Depth; k++) add_req(REQ_FREE, size_in_class(c), rand_addr(), '0);
    end
    add_req(REQ_TRIM, $urandom, rand_addr(), '0);
    queue_random(28);
    settle();

    write_thresh('0);
    queue_random(25);
    settle();

    write_thresh(40'd65536);
    queue_random(30);
    settle();

    write_thresh(ThreshRst);
    queue_random(30);
    settle();

    write_thresh($urandom_range(0, 1 << 22));
    queue_random(25);
    settle();

    $display("run covered %0d requests, %0d beats, %0d trims (longest %0d beats), %0d thresholds",
             n_req, n_beats, n_trims, longest_trim, n_cfg);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("mismatches: %0d", errors);
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d beats outstanding", beats_due.size());
    $display("tb: errors");
    $finish;
  end

endmodule

[filelist.f]
sv/scbp_pkg.sv
sv/scbp_ram.sv
sv/scbp_alu.sv
sv/scbp_seq.sv
sv/size_class_block_pool.sv
test/tb.sv
